FILE: src/memory_to_memory_instruction_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the memory-to-memory instruction core.
// Define ASSERT_OFF to compile every check away.
// ----------------------------------------------------------------------------
`ifndef MEMORY_TO_MEMORY_INSTRUCTION_CORE_ASSERT_SVH
`define MEMORY_TO_MEMORY_INSTRUCTION_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is low.
`define MTM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define MTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define MTM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define MTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: src/mtm_pkg.sv
// ----------------------------------------------------------------------------
// mtm_pkg
// Types and constants shared by the memory-to-memory instruction core.
// ----------------------------------------------------------------------------
package mtm_pkg;

  localparam int unsigned MemDepth = 256;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned DataW    = 32;
  localparam int unsigned ThirdW   = 8;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_STEP = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    OP_READ   = 4'd0,
    OP_WRITE  = 4'd1,
    OP_ASSIGN = 4'd2,
    OP_MOVE   = 4'd3,
    OP_LOAD   = 4'd4,
    OP_STORE  = 4'd5,
    OP_ADD    = 4'd6,
    OP_SUB    = 4'd7,
    OP_MULT   = 4'd8,
    OP_MOD    = 4'd9,
    OP_EQ     = 4'd10,
    OP_LESS   = 4'd11,
    OP_JUMP   = 4'd12,
    OP_JUMPIF = 4'd13,
    OP_TERM   = 4'd14,
    OP_DATA   = 4'd15
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TERM    = 3'd1,
    ST_UNSUP   = 3'd2,
    ST_MODZERO = 3'd3,
    ST_HALTED  = 3'd4
  } status_e;

  // Code part of one entry; the data word lives in a memory of its own.
  typedef struct packed {
    opcode_e             kind;
    logic [DataW-1:0]    second;
    logic [ThirdW-1:0]   third;
  } code_t;

  typedef struct packed {
    req_type_e           req_type;
    logic [AddrW-1:0]    entry_addr;
    opcode_e             entry_opcode;
    logic [DataW-1:0]    operand_first;
    logic [DataW-1:0]    operand_second;
    logic [ThirdW-1:0]   operand_third;
    logic [DataW-1:0]    input_value;
  } req_t;

  typedef struct packed {
    logic                out_valid;
    logic [DataW-1:0]    out_value;
    logic [DataW-1:0]    read_data;
    logic [AddrW-1:0]    prog_counter;
    status_e             status;
    logic                is_halted;
  } rsp_t;

  typedef struct packed {
    logic                code_we;
    logic                data_we;
    logic [AddrW-1:0]    waddr;
    code_t               code_wdata;
    logic [DataW-1:0]    data_wdata;
    logic [AddrW-1:0]    code_raddr;
    logic [AddrW-1:0]    data_raddr;
  } store_req_t;

  typedef struct packed {
    logic                start;
    logic [DataW-1:0]    dividend;
    logic [DataW-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DataW-1:0]    remainder;
  } div_rsp_t;

endpackage

FILE: src/mtm_req_if.sv
// ----------------------------------------------------------------------------
// mtm_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface mtm_req_if import mtm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [AddrW-1:0]         entry_addr;
  logic [3:0]               entry_opcode;
  logic signed [DataW-1:0]  operand_first;
  logic signed [DataW-1:0]  operand_second;
  logic [ThirdW-1:0]        operand_third;
  logic signed [DataW-1:0]  input_value;

  modport source (
    output valid, req_type, entry_addr, entry_opcode, operand_first,
           operand_second, operand_third, input_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_addr, entry_opcode, operand_first,
           operand_second, operand_third, input_value,
    output ready
  );
endinterface

FILE: src/mtm_rsp_if.sv
// ----------------------------------------------------------------------------
// mtm_rsp_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface mtm_rsp_if import mtm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     out_valid;
  logic signed [DataW-1:0]  out_value;
  logic signed [DataW-1:0]  read_data;
  logic [AddrW-1:0]         prog_counter;
  logic [2:0]               status;
  logic                     is_halted;

  modport source (
    output valid, out_valid, out_value, read_data, prog_counter, status, is_halted,
    input  ready
  );
  modport sink (
    input  valid, out_valid, out_value, read_data, prog_counter, status, is_halted,
    output ready
  );
endinterface

FILE: src/memory_to_memory_instruction_core.sv
// ----------------------------------------------------------------------------
// memory_to_memory_instruction_core
// Memory-to-memory machine with 256 entries of opcode and three operands.
//
//   Channel  Dir  Transfer when      Payload
//   req_i    in   valid && ready     req_type, entry_addr, entry_opcode,
//                                    operand_first/second/third, input_value
//   rsp_o    out  valid && ready     out_valid, out_value, read_data,
//                                    prog_counter, status, is_halted
//
// One request is worked on at a time. A step runs through fetch, one data
// memory read per operand, execute and hand-off, set by the single read port
// of the data memory. A modulo step also waits on the remainder unit, which
// works one bit per cycle.
// Reset clears the store valid bits at once; no clearing pass is needed.
// A stalled result sits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module memory_to_memory_instruction_core import mtm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtm_req_if.sink   req_i,
  mtm_rsp_if.source rsp_o
);

  req_t       req;
  rsp_t       res;
  logic       res_valid;
  logic       res_ready;
  store_req_t st_req;
  code_t      code_rd;
  logic [DataW-1:0] data_rd;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  rsp_t       out_q;
  logic       out_vld_q;

  always_comb begin
    req.req_type       = req_type_e'(req_i.req_type);
    req.entry_addr     = req_i.entry_addr;
    req.entry_opcode   = opcode_e'(req_i.entry_opcode);
    req.operand_first  = req_i.operand_first;
    req.operand_second = req_i.operand_second;
    req.operand_third  = req_i.operand_third;
    req.input_value    = req_i.input_value;
  end

  mtm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .st_o        (st_req),
    .code_i      (code_rd),
    .data_i      (data_rd),
    .div_o       (div_req),
    .div_i       (div_rsp)
  );

  mtm_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (st_req),
    .code_o (code_rd),
    .data_o (data_rd)
  );

  mtm_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register: takes a new result when empty or when the current one
  // leaves in the same cycle.
  assign res_ready = !out_vld_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.out_valid    = out_q.out_valid;
  assign rsp_o.out_value    = out_q.out_value;
  assign rsp_o.read_data    = out_q.read_data;
  assign rsp_o.prog_counter = out_q.prog_counter;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.is_halted    = out_q.is_halted;

endmodule

FILE: src/mtm_store.sv
// ----------------------------------------------------------------------------
// mtm_store
// Entry store: a code memory and a data word memory, one write and one
// registered read each, with one valid bit per entry for the reset contents.
// ----------------------------------------------------------------------------
module mtm_store import mtm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_req_t       req_i,
  output code_t            code_o,
  output logic [DataW-1:0] data_o
);

  localparam code_t CodeReset = '{kind: OP_DATA, second: '0, third: '0};

  code_t            code_mem [MemDepth];
  logic [DataW-1:0] data_mem [MemDepth];

  logic [MemDepth-1:0] vld_q;
  code_t               code_rd_q;
  logic [DataW-1:0]    data_rd_q;
  logic                code_rvld_q;
  logic                data_rvld_q;

  logic                code_wr;
  logic                data_wr;
  code_t               code_wdata;
  logic [DataW-1:0]    data_wdata;

  // The first write to an entry fills both memories, taking the reset value
  // for the half that is not written, so one valid bit covers the pair.
  always_comb begin
    code_wr    = req_i.code_we || (req_i.data_we && !vld_q[req_i.waddr]);
    data_wr    = req_i.data_we || (req_i.code_we && !vld_q[req_i.waddr]);
    code_wdata = req_i.code_we ? req_i.code_wdata : CodeReset;
    data_wdata = req_i.data_we ? req_i.data_wdata : '0;
  end

  always_ff @(posedge clk_i) begin
    if (code_wr) begin
      code_mem[req_i.waddr] <= code_wdata;
    end
    if (data_wr) begin
      data_mem[req_i.waddr] <= data_wdata;
    end
    code_rd_q <= code_mem[req_i.code_raddr];
    data_rd_q <= data_mem[req_i.data_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      code_rvld_q <= 1'b0;
      data_rvld_q <= 1'b0;
    end else begin
      if (req_i.code_we || req_i.data_we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      code_rvld_q <= vld_q[req_i.code_raddr];
      data_rvld_q <= vld_q[req_i.data_raddr];
    end
  end

  // An entry never written reads as plain data with zero words.
  assign code_o = code_rvld_q ? code_rd_q : CodeReset;
  assign data_o = data_rvld_q ? data_rd_q : '0;

endmodule

FILE: src/mtm_divider.sv
// ----------------------------------------------------------------------------
// mtm_divider
// Iterative signed remainder, one restoring step per cycle on magnitudes.
// The remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module mtm_divider import mtm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] quo_q;
  logic [DataW-1:0] dvs_q;
  logic             neg_q;

  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;
  logic [DataW-1:0] rem_next;

  always_comb begin
    shifted  = {rem_q, quo_q[DataW-1]};
    diff     = shifted - {1'b0, dvs_q};
    rem_next = diff[DataW] ? shifted[DataW-1:0] : diff[DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[DataW-1];
      quo_q <= req_i.dividend[DataW-1] ? -req_i.dividend : req_i.dividend;
      dvs_q <= req_i.divisor[DataW-1] ? -req_i.divisor : req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[DataW-2:0], 1'b0};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = neg_q ? -rem_q : rem_q;

endmodule

FILE: src/mtm_ctrl.sv
// ----------------------------------------------------------------------------
// mtm_ctrl
// Sequencer: fetches the entry at the program counter, reads its operands
// from the data memory one per cycle, executes and writes the result back.
// ----------------------------------------------------------------------------
`include "memory_to_memory_instruction_core_assert.svh"

module mtm_ctrl import mtm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output rsp_t             res_o,
  output store_req_t       st_o,
  input  code_t            code_i,
  input  logic [DataW-1:0] data_i,
  output div_req_t         div_o,
  input  div_rsp_t         div_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_FETCH,
    S_OPA,
    S_EXEC,
    S_DIV,
    S_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  pc_q, pc_d;
  logic              halt_q, halt_d;
  opcode_e           kind_q, kind_d;
  logic [AddrW-1:0]  f_q, f_d;
  logic [DataW-1:0]  s_q, s_d;
  logic [ThirdW-1:0] t_q, t_d;
  logic [DataW-1:0]  a_q, a_d;
  logic [DataW-1:0]  inval_q, inval_d;
  rsp_t              res_q, res_d;
  logic [AddrW-1:0]  next_pc;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    halt_d  = halt_q;
    kind_d  = kind_q;
    f_d     = f_q;
    s_d     = s_q;
    t_d     = t_q;
    a_d     = a_q;
    inval_d = inval_q;
    res_d   = res_q;
    next_pc = pc_q + AddrW'(1);

    st_o            = '0;
    st_o.code_raddr = pc_q;
    st_o.data_raddr = pc_q;
    st_o.waddr      = f_q;

    div_o          = '0;
    div_o.dividend = a_q;
    div_o.divisor  = data_i;

    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          res_d              = '0;
          res_d.status       = ST_OK;
          res_d.prog_counter = pc_q;
          res_d.is_halted    = halt_q;
          state_d            = S_RESP;
          case (req_i.req_type)
            REQ_LOAD: begin
              st_o.code_we           = 1'b1;
              st_o.data_we           = 1'b1;
              st_o.waddr             = req_i.entry_addr;
              st_o.code_wdata.kind   = req_i.entry_opcode;
              st_o.code_wdata.second = req_i.operand_second;
              st_o.code_wdata.third  = req_i.operand_third;
              st_o.data_wdata        = req_i.operand_first;
            end
            REQ_READ: begin
              st_o.data_raddr = req_i.entry_addr;
              state_d         = S_RDATA;
            end
            REQ_STEP: begin
              if (halt_q) begin
                res_d.status = ST_HALTED;
              end else begin
                inval_d = req_i.input_value;
                state_d = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RDATA: begin
        res_d.read_data = data_i;
        state_d         = S_RESP;
      end

      S_FETCH: begin
        kind_d          = code_i.kind;
        s_d             = code_i.second;
        t_d             = code_i.third;
        f_d             = data_i[AddrW-1:0];
        st_o.data_raddr = code_i.second[AddrW-1:0];
        state_d         = S_OPA;
      end

      S_OPA: begin
        // Second operand read: [[s]] for load, [f] for write and store, else [t].
        a_d = data_i;
        if (kind_q == OP_LOAD) begin
          st_o.data_raddr = data_i[AddrW-1:0];
        end else if (kind_q inside {OP_WRITE, OP_STORE}) begin
          st_o.data_raddr = f_q;
        end else begin
          st_o.data_raddr = t_q;
        end
        state_d = S_EXEC;
      end

      S_EXEC: begin
        res_d        = '0;
        res_d.status = ST_OK;
        state_d      = S_RESP;
        case (kind_q)
          OP_READ: begin
            st_o.data_we    = 1'b1;
            st_o.data_wdata = inval_q;
          end
          OP_WRITE: begin
            res_d.out_valid = 1'b1;
            res_d.out_value = data_i;
          end
          OP_ASSIGN: begin
            st_o.data_we    = 1'b1;
            st_o.data_wdata = s_q;
          end
          OP_MOVE: begin
            st_o.data_we    = 1'b1;
            st_o.data_wdata = a_q;
          end
          OP_LOAD: begin
            st_o.data_we    = 1'b1;
            st_o.data_wdata = data_i;
          end
          OP_STORE: begin
            st_o.data_we    = 1'b1;
            st_o.waddr      = a_q[AddrW-1:0];
            st_o.data_wdata = data_i;
          end
          OP_ADD: begin
            st_o.data_we    = 1'b1;
            st_o.data_wdata = a_q + data_i;
          end
          OP_SUB: begin
            st_o.data_we    = 1'b1;
            st_o.data_wdata = a_q - data_i;
          end
          OP_MULT: begin
            st_o.data_we    = 1'b1;
            st_o.data_wdata = a_q * data_i;
          end
          OP_MOD: begin
            if (data_i == '0) begin
              st_o.data_we    = 1'b1;
              st_o.data_wdata = '0;
              res_d.status    = ST_MODZERO;
            end else begin
              div_o.start = 1'b1;
              state_d     = S_DIV;
            end
          end
          OP_EQ: begin
            st_o.data_we    = 1'b1;
            st_o.data_wdata = {{(DataW-1){1'b0}}, a_q == data_i};
          end
          OP_LESS: begin
            st_o.data_we    = 1'b1;
            st_o.data_wdata = {{(DataW-1){1'b0}}, $signed(a_q) < $signed(data_i)};
          end
          OP_JUMP: begin
            next_pc = f_q;
          end
          OP_JUMPIF: begin
            if (a_q != '0) begin
              next_pc = f_q;
            end
          end
          OP_TERM: begin
            res_d.status = ST_TERM;
            halt_d       = 1'b1;
            next_pc      = pc_q;
          end
          default: begin
            // A plain data entry reached as code stops the machine.
            res_d.status = ST_UNSUP;
            halt_d       = 1'b1;
            next_pc      = pc_q;
          end
        endcase
        pc_d               = next_pc;
        res_d.prog_counter = next_pc;
        res_d.is_halted    = halt_d;
      end

      S_DIV: begin
        if (div_i.done) begin
          st_o.data_we    = 1'b1;
          st_o.data_wdata = div_i.remainder;
          state_d         = S_RESP;
        end
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      halt_q  <= 1'b0;
      kind_q  <= OP_DATA;
      f_q     <= '0;
      s_q     <= '0;
      t_q     <= '0;
      a_q     <= '0;
      inval_q <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      kind_q  <= kind_d;
      f_q     <= f_d;
      s_q     <= s_d;
      t_q     <= t_d;
      a_q     <= a_d;
      inval_q <= inval_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

  `MTM_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halt_q, halt_q, "halt cleared without reset")
  `MTM_ASSERT_IMPLY(a_div_from_exec, clk_i, rst_ni, div_o.start, state_q == S_EXEC, "divider started outside execute")
  `MTM_ASSERT_IMPLY(a_pc_at_exec, clk_i, rst_ni, pc_q != $past(pc_q), $past(state_q) == S_EXEC, "pc moved outside execute")
  `MTM_ASSERT_IMPLY(a_code_wr_load, clk_i, rst_ni, st_o.code_we, state_q == S_IDLE && req_valid_i && req_i.req_type == REQ_LOAD, "code write without load transfer")

endmodule

FILE: test/memory_to_memory_instruction_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_to_memory_instruction_core_test
// Drives load, step, read and idle requests into the instruction core and
// checks every result against a cycle-free model of the machine kept here.
// A short directed program runs every non-halting opcode first. The store is then filled
// with non-halting code and random requests follow. The run ends by halting
// the machine and poking it while halted.
// ----------------------------------------------------------------------------
module memory_to_memory_instruction_core_test;
  import mtm_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam logic [DataW-1:0] MinWord = 32'h8000_0000;
  localparam logic [DataW-1:0] MaxWord = 32'h7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni;

  mtm_req_if req_if ();
  mtm_rsp_if rsp_if ();

  memory_to_memory_instruction_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Machine state as the requests leave it.
  opcode_e           instr_kind  [MemDepth];
  logic [DataW-1:0]  data_word   [MemDepth];
  logic [DataW-1:0]  second_word [MemDepth];
  logic [ThirdW-1:0] third_index [MemDepth];
  logic [AddrW-1:0]  machine_pc;
  logic              machine_halted;

  req_t request_q[$];
  rsp_t due_results[$];

  int  mismatches;
  int  n_load, n_step, n_read, n_none, n_emit, n_modzero;
  bit  req_taken;
  bit  quiet_tail;
  int  send_gap, recv_gap;
  int  stall_cycles;

  function automatic rsp_t machine_execute(req_t rq);
    rsp_t             rs;
    logic [DataW-1:0] f, s, a, b, ma, mb, r;
    logic [ThirdW-1:0] t;
    logic [AddrW-1:0] nxt;
    rs = '0;
    rs.status = ST_OK;
    case (rq.req_type)
      REQ_LOAD: begin
        instr_kind[rq.entry_addr]  = rq.entry_opcode;
        data_word[rq.entry_addr]   = rq.operand_first;
        second_word[rq.entry_addr] = rq.operand_second;
        third_index[rq.entry_addr] = rq.operand_third;
      end
      REQ_READ: rs.read_data = data_word[rq.entry_addr];
      REQ_STEP: begin
        if (machine_halted) begin
          rs.status = ST_HALTED;
        end else begin
          f = data_word[machine_pc];
          s = second_word[machine_pc];
          t = third_index[machine_pc];
          a = data_word[s[AddrW-1:0]];
          b = data_word[t];
          nxt = machine_pc + 1'b1;
          case (instr_kind[machine_pc])
            OP_READ:   data_word[f[AddrW-1:0]] = rq.input_value;
            OP_WRITE: begin
              rs.out_valid = 1'b1;
              rs.out_value = data_word[f[AddrW-1:0]];
            end
            OP_ASSIGN: data_word[f[AddrW-1:0]] = s;
            OP_MOVE:   data_word[f[AddrW-1:0]] = a;
            OP_LOAD:   data_word[f[AddrW-1:0]] = data_word[a[AddrW-1:0]];
            OP_STORE:  data_word[a[AddrW-1:0]] = data_word[f[AddrW-1:0]];
            OP_ADD:    data_word[f[AddrW-1:0]] = a + b;
            OP_SUB:    data_word[f[AddrW-1:0]] = a - b;
            OP_MULT:   data_word[f[AddrW-1:0]] = a * b;
            OP_MOD: begin
              if (b == '0) begin
                data_word[f[AddrW-1:0]] = '0;
                rs.status = ST_MODZERO;
              end else begin
                // Truncated remainder: sign follows the dividend.
                ma = a[DataW-1] ? -a : a;
                mb = b[DataW-1] ? -b : b;
                r  = ma % mb;
                data_word[f[AddrW-1:0]] = a[DataW-1] ? -r : r;
              end
            end
            OP_EQ:     data_word[f[AddrW-1:0]] = (a == b) ? 1 : 0;
            OP_LESS:   data_word[f[AddrW-1:0]] = ($signed(a) < $signed(b)) ? 1 : 0;
            OP_JUMP:   nxt = f[AddrW-1:0];
            OP_JUMPIF: if (a != '0) nxt = f[AddrW-1:0];
            OP_TERM: begin
              rs.status = ST_TERM;
              machine_halted = 1'b1;
              nxt = machine_pc;
            end
            default: begin
              rs.status = ST_UNSUP;
              machine_halted = 1'b1;
              nxt = machine_pc;
            end
          endcase
          machine_pc = nxt;
        end
      end
      default: ;
    endcase
    rs.prog_counter = machine_pc;
    rs.is_halted    = machine_halted;
    return rs;
  endfunction

  // Address and third operand come in as full words and keep their low bits.
  function automatic req_t make_req(req_type_e kind, logic [DataW-1:0] addr, opcode_e op,
                                    logic [DataW-1:0] f, logic [DataW-1:0] s,
                                    logic [DataW-1:0] t, logic [DataW-1:0] inval);
    req_t rq;
    rq.req_type       = kind;
    rq.entry_addr     = addr[AddrW-1:0];
    rq.entry_opcode   = op;
    rq.operand_first  = f;
    rq.operand_second = s;
    rq.operand_third  = t[ThirdW-1:0];
    rq.input_value    = inval;
    return rq;
  endfunction

  // Words are biased toward the values that stress arithmetic and indexing.
  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      3:       return MinWord;
      4:       return MaxWord;
      5:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_load(bit allow_halt);
    return make_req(REQ_LOAD, $urandom_range(0, 255),
                    opcode_e'($urandom_range(0, allow_halt ? 15 : 13)),
                    pick_word(), pick_word(), $urandom_range(0, 255), $urandom);
  endfunction

  function automatic void check_field(string name, logic [DataW-1:0] want,
                                      logic [DataW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic wait_accepted();
    while (request_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || due_results.size() != 0) @(negedge clk_i);
  endtask

  // Loads one instruction at the current program counter and executes it.
  task automatic run_instr(opcode_e op, logic [DataW-1:0] f, logic [DataW-1:0] s,
                           logic [DataW-1:0] t, logic [DataW-1:0] inval);
    wait_accepted();
    request_q.push_back(make_req(REQ_LOAD, DataW'(machine_pc), op, f, s, t, $urandom));
    request_q.push_back(make_req(REQ_STEP, $urandom, opcode_e'($urandom), $urandom,
                                 $urandom, $urandom, inval));
  endtask

  // Request side: a transfer is taken at the rising edge.
  always @(posedge clk_i) begin : req_accept
    req_t rq;
    rsp_t rs;
    if (rst_ni && req_if.valid && req_if.ready) begin
      rq.req_type       = req_type_e'(req_if.req_type);
      rq.entry_addr     = req_if.entry_addr;
      rq.entry_opcode   = opcode_e'(req_if.entry_opcode);
      rq.operand_first  = req_if.operand_first;
      rq.operand_second = req_if.operand_second;
      rq.operand_third  = req_if.operand_third;
      rq.input_value    = req_if.input_value;
      rs = machine_execute(rq);
      due_results.push_back(rs);
      void'(request_q.pop_front());
      req_taken = 1'b1;
      case (rq.req_type)
        REQ_LOAD: n_load++;
        REQ_STEP: n_step++;
        REQ_READ: n_read++;
        default:  n_none++;
      endcase
      if (rs.out_valid) n_emit++;
      if (rs.status == ST_MODZERO) n_modzero++;
    end
  end

  always @(negedge clk_i) begin : req_driver
    bit taken;
    taken = req_taken;
    req_taken = 1'b0;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !taken) begin
      // Hold the offered item until its transfer.
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      req_if.valid <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      send_gap <= $urandom_range(0, 8);
      req_if.valid <= 1'b0;
    end else if (request_q.size() != 0) begin
      req_if.valid          <= 1'b1;
      req_if.req_type       <= request_q[0].req_type;
      req_if.entry_addr     <= request_q[0].entry_addr;
      req_if.entry_opcode   <= request_q[0].entry_opcode;
      req_if.operand_first  <= request_q[0].operand_first;
      req_if.operand_second <= request_q[0].operand_second;
      req_if.operand_third  <= request_q[0].operand_third;
      req_if.input_value    <= request_q[0].input_value;
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin : rsp_ready_driver
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      rsp_if.ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 8);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : rsp_monitor
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual pc %0h status %0d",
                 $time, rsp_if.prog_counter, rsp_if.status);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("out_valid", DataW'(want.out_valid), DataW'(rsp_if.out_valid));
        check_field("out_value", want.out_value, rsp_if.out_value);
        check_field("read_data", want.read_data, rsp_if.read_data);
        check_field("prog_counter", DataW'(want.prog_counter),
                    DataW'(rsp_if.prog_counter));
        check_field("status", DataW'(want.status), DataW'(rsp_if.status));
        check_field("is_halted", DataW'(want.is_halted), DataW'(rsp_if.is_halted));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == StallLimit) begin
        $display("Watchdog: no transfer for %0d cycles at %0t", StallLimit, $time);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    opcode_e halt_kind, other_kind;
    int      sel;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.req_type       = '0;
    req_if.entry_addr     = '0;
    req_if.entry_opcode   = '0;
    req_if.operand_first  = '0;
    req_if.operand_second = '0;
    req_if.operand_third  = '0;
    req_if.input_value    = '0;
    rsp_if.ready   = 1'b0;
    for (int i = 0; i < MemDepth; i++) begin
      instr_kind[i]  = OP_DATA;
      data_word[i]   = '0;
      second_word[i] = '0;
      third_index[i] = '0;
    end
    machine_pc     = '0;
    machine_halted = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed program; high operand bits check that indexes wrap.
    run_instr(OP_READ,   32'h1234_56c8, $urandom, $urandom, MinWord);      // [200] = min
    run_instr(OP_ASSIGN, 32'hffff_ffc9, '1, $urandom, $urandom);           // [201] = -1
    run_instr(OP_ADD,    202, 32'h8000_00c8, 201, $urandom);               // min-1 -> max
    run_instr(OP_SUB,    204, 202, 201, $urandom);                         // max+1 -> min
    run_instr(OP_MULT,   205, 202, 202, $urandom);
    run_instr(OP_MOD,    206, 200, 201, $urandom);                         // min rem -1
    run_instr(OP_MOD,    207, 202, 203, $urandom);                         // divide by zero
    run_instr(OP_EQ,     208, 200, 204, $urandom);
    run_instr(OP_LESS,   209, 200, 202, $urandom);
    run_instr(OP_MOVE,   210, 201, $urandom, $urandom);
    run_instr(OP_STORE,  202, 209, $urandom, $urandom);                    // [[209]] = [202]
    run_instr(OP_LOAD,   211, 201, $urandom, $urandom);                    // [[201]] wraps
    run_instr(OP_WRITE,  204, $urandom, $urandom, $urandom);
    run_instr(OP_JUMPIF, 32'h0000_01f0, 202, $urandom, $urandom);          // taken, to 240
    run_instr(OP_JUMP,   32'hffff_ff40, $urandom, $urandom, $urandom);     // to 64
    request_q.push_back(make_req(REQ_READ, 202, OP_DATA, '0, '0, '0, '0));
    request_q.push_back(make_req(REQ_READ, 255, OP_DATA, '0, '0, '0, '0));
    request_q.push_back(make_req(REQ_NONE, '1, OP_DATA, '1, '1, '1, '1));
    wait_idle();

    // Fill every entry with non-halting code so random stepping never stops.
    for (int i = 0; i < MemDepth; i++) begin
      request_q.push_back(make_req(REQ_LOAD, i, opcode_e'($urandom_range(0, 13)),
                                   pick_word(), pick_word(), $urandom_range(0, 255),
                                   $urandom));
    end

    for (int i = 0; i < 250; i++) begin
      if (i % 60 == 59) wait_idle();
      if (i == 210) quiet_tail = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        request_q.push_back(random_load(1'b0));
      end else if (sel < 75) begin
        request_q.push_back(make_req(REQ_STEP, $urandom, opcode_e'($urandom), $urandom,
                                     $urandom, $urandom, pick_word()));
      end else if (sel < 92) begin
        request_q.push_back(make_req(REQ_READ, $urandom, opcode_e'($urandom), $urandom,
                                     $urandom, $urandom, $urandom));
      end else begin
        request_q.push_back(make_req(REQ_NONE, $urandom, opcode_e'($urandom), $urandom,
                                     $urandom, $urandom, $urandom));
      end
    end

    // Stop the machine, then keep using the store while it is halted.
    wait_idle();
    halt_kind  = $urandom_range(0, 1) ? OP_TERM : OP_DATA;
    other_kind = (halt_kind == OP_TERM) ? OP_DATA : OP_TERM;
    request_q.push_back(make_req(REQ_LOAD, DataW'(machine_pc), halt_kind, pick_word(),
                                 pick_word(), $urandom, $urandom));
    request_q.push_back(make_req(REQ_LOAD, DataW'(machine_pc + 1'b1), other_kind,
                                 pick_word(), pick_word(), $urandom, $urandom));
    request_q.push_back(make_req(REQ_STEP, '0, OP_READ, '0, '0, '0, $urandom));
    request_q.push_back(make_req(REQ_STEP, '0, OP_READ, '0, '0, '0, $urandom));
    request_q.push_back(random_load(1'b1));
    request_q.push_back(make_req(REQ_READ, DataW'(machine_pc), OP_DATA, '0, '0, '0, '0));
    request_q.push_back(make_req(REQ_STEP, '0, OP_READ, '0, '0, '0, $urandom));
    request_q.push_back(make_req(REQ_NONE, $urandom, opcode_e'($urandom), $urandom,
                                 $urandom, $urandom, $urandom));
    request_q.push_back(make_req(REQ_READ, $urandom, OP_DATA, '0, '0, '0, '0));
    wait_idle();
    repeat (40) @(negedge clk_i);

    $display("Covered %0d loads, %0d steps, %0d reads and %0d no-op requests.",
             n_load, n_step, n_read, n_none);
    $display("Steps emitted %0d values and hit %0d zero divisors; final halt by opcode %0d.",
             n_emit, n_modzero, halt_kind);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/mtm_pkg.sv
src/mtm_req_if.sv
src/mtm_rsp_if.sv
src/mtm_store.sv
src/mtm_divider.sv
src/mtm_ctrl.sv
src/memory_to_memory_instruction_core.sv
test/memory_to_memory_instruction_core_test.sv
